### sv/gtp_pkg.sv
// package: types, constants and tables of the go-to-point steering core
package gtp_pkg;

    localparam int CORDIC_STEPS = 12;
    localparam int SQRT_STEPS   = 17;
    localparam int STEP_W       = 5;

    localparam logic [2:0] REG_TARGET_X   = 3'd0;
    localparam logic [2:0] REG_TARGET_Y   = 3'd1;
    localparam logic [2:0] REG_GAIN       = 3'd2;
    localparam logic [2:0] REG_MAX_SPEED  = 3'd3;
    localparam logic [2:0] REG_ARRIVE_THR = 3'd4;
    localparam logic [2:0] REG_HEAD_THR   = 3'd5;

    localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;

    typedef struct packed {
        logic        [33:0] rem;
        logic        [33:0] root;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [19:0] z;
        logic signed [10:0] hd;
    } t_iter;

    function automatic logic signed [19:0] atan_q16(input logic [STEP_W-1:0] i);
        logic signed [19:0] v;
        case (i)
            5'd0:    v = 20'sd51472;
            5'd1:    v = 20'sd30385;
            5'd2:    v = 20'sd16055;
            5'd3:    v = 20'sd8150;
            5'd4:    v = 20'sd4091;
            5'd5:    v = 20'sd2047;
            5'd6:    v = 20'sd1024;
            5'd7:    v = 20'sd512;
            5'd8:    v = 20'sd256;
            5'd9:    v = 20'sd128;
            5'd10:   v = 20'sd64;
            5'd11:   v = 20'sd32;
            5'd12:   v = 20'sd16;
            5'd13:   v = 20'sd8;
            5'd14:   v = 20'sd4;
            5'd15:   v = 20'sd2;
            default: v = 20'sd0;
        endcase
        return v;
    endfunction

endpackage

### sv/gtp_pose_if.sv
// interface: pose channel
interface gtp_pose_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [10:0] heading;
    modport source (output valid, pos_x, pos_y, heading, input ready);
    modport sink   (input valid, pos_x, pos_y, heading, output ready);
endinterface

### sv/gtp_cmd_if.sv
// interface: drive command channel
interface gtp_cmd_if;
    logic        valid;
    logic        ready;
    logic [15:0] linear_speed;
    logic [10:0] turn_rate;
    modport source (output valid, linear_speed, turn_rate, input ready);
    modport sink   (input valid, linear_speed, turn_rate, output ready);
endinterface

### sv/gtp_front.sv
// front stages: offsets to target, squared distance, cordic pre-rotation
module gtp_front import gtp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic signed [10:0] i_heading,
    input  logic signed [15:0] i_target_x,
    input  logic signed [15:0] i_target_y,
    output logic               o_valid,
    output t_iter              o_data
);
    logic               r_v1;
    logic signed [16:0] r_dx, r_dy;
    logic signed [10:0] r_hd;
    logic               r_v2;
    t_iter              r_d2;
    logic signed [16:0] n_dx, n_dy;
    logic signed [33:0] sq_x, sq_y;
    logic signed [31:0] x0, y0;
    t_iter              n_d2;

    // offsets to target
    assign n_dx = {i_target_x[15], i_target_x} - {i_pos_x[15], i_pos_x};
    assign n_dy = {i_target_y[15], i_target_y} - {i_pos_y[15], i_pos_y};

    // squares and pre-rotation into the right half plane
    assign sq_x = r_dx * r_dx;
    assign sq_y = r_dy * r_dy;
    assign x0 = {{3{r_dx[16]}}, r_dx, 12'b0};
    assign y0 = {{3{r_dy[16]}}, r_dy, 12'b0};
    always_comb begin
        n_d2.rem  = 34'(sq_x) + 34'(sq_y);
        n_d2.root = '0;
        n_d2.hd   = r_hd;
        n_d2.x    = x0;
        n_d2.y    = y0;
        n_d2.z    = '0;
        if (x0 < 0) begin
            if (y0 >= 0) begin
                n_d2.x = y0;
                n_d2.y = -x0;
                n_d2.z = HALF_PI_Q16;
            end else begin
                n_d2.x = -y0;
                n_d2.y = x0;
                n_d2.z = -HALF_PI_Q16;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx <= n_dx;
            r_dy <= n_dy;
            r_hd <= i_heading;
            r_d2 <= n_d2;
        end
    end

    assign o_valid = r_v2;
    assign o_data  = r_d2;
endmodule

### sv/gtp_iter.sv
// one pipeline stage: one square root bit and, for steps below CORDIC_STEPS, one cordic rotation
module gtp_iter import gtp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [STEP_W-1:0] i_step,
    input  logic              i_valid,
    input  t_iter             i_data,
    output logic              o_valid,
    output t_iter             o_data
);
    logic               r_valid;
    t_iter              r_data;
    t_iter              n_data;
    logic        [33:0] bit_v;
    logic        [33:0] trial;
    logic signed [31:0] xs, ys;

    assign bit_v = 34'(1) << (6'd32 - {i_step, 1'b0});
    assign trial = i_data.root + bit_v;
    assign xs    = i_data.x >>> i_step;
    assign ys    = i_data.y >>> i_step;

    always_comb begin
        n_data = i_data;
        // restoring square root step
        if (i_data.rem >= trial) begin
            n_data.rem  = i_data.rem - trial;
            n_data.root = (i_data.root >> 1) + bit_v;
        end else begin
            n_data.root = i_data.root >> 1;
        end
        // vectoring rotation towards the x axis
        if (32'(i_step) < 32'(CORDIC_STEPS)) begin
            if (i_data.y > 0) begin
                n_data.x = i_data.x + ys;
                n_data.y = i_data.y - xs;
                n_data.z = i_data.z + atan_q16(i_step);
            end else begin
                n_data.x = i_data.x - ys;
                n_data.y = i_data.y + xs;
                n_data.z = i_data.z - atan_q16(i_step);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

### sv/gtp_back.sv
// back stages: bearing error, branch decision, gain product and clamp
module gtp_back import gtp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_iter       i_data,
    input  logic [15:0] i_gain,
    input  logic [15:0] i_max_speed,
    input  logic [15:0] i_arrive_thr,
    input  logic [10:0] i_head_thr,
    output logic        o_valid,
    output logic [15:0] o_linear_speed,
    output logic [10:0] o_turn_rate
);
    logic               r_v1, r_go, r_turn;
    logic        [10:0] r_aerr;
    logic        [32:0] r_prod;
    logic               r_v2;
    logic        [15:0] r_lin;
    logic        [10:0] r_turn_rate;
    logic        [16:0] distance;
    logic signed [19:0] z_rnd;
    logic signed [11:0] bearing;
    logic signed [12:0] err;
    logic        [11:0] aerr;
    logic        [24:0] lin_full;
    logic        [15:0] n_lin;
    logic        [10:0] n_turn_rate;

    // rounded bearing minus heading, unwrapped
    assign distance = i_data.root[16:0];
    assign z_rnd    = (i_data.z + 20'sd128) >>> 8;
    assign bearing  = z_rnd[11:0];
    assign err      = {bearing[11], bearing} - {{2{i_data.hd[10]}}, i_data.hd};
    assign aerr     = err[12] ? 12'(-err) : err[11:0];

    // speed clamp and branch select
    assign lin_full = r_prod[32:8];
    always_comb begin
        n_lin       = '0;
        n_turn_rate = '0;
        if (r_go) begin
            if (r_turn) begin
                n_turn_rate = r_aerr;
            end else if (lin_full > 25'(i_max_speed)) begin
                n_lin = i_max_speed;
            end else begin
                n_lin = lin_full[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_go        <= distance > 17'(i_arrive_thr);
            r_turn      <= aerr > 12'(i_head_thr);
            r_aerr      <= aerr[10:0];
            r_prod      <= i_gain * distance;
            r_lin       <= n_lin;
            r_turn_rate <= n_turn_rate;
        end
    end

    assign o_valid        = r_v2;
    assign o_linear_speed = r_lin;
    assign o_turn_rate    = r_turn_rate;
endmodule

### sv/go_to_point_proportional_steer_core.sv
// top level: proportional go-to-point steering core
// Takes one pose per cycle and gives one drive command per pose, in order.
// It has two front stages (offsets, squares and pre-rotation), seventeen
// iteration stages that each resolve one bit of the distance square root
// and, in the first CORDIC_STEPS of them, one bearing rotation, and two
// back stages (error and gain product, clamp). The whole pipeline advances
// together; when the command sink stalls, the pipeline holds and the pose
// channel stops accepting. Configuration registers may be written only
// while no pose is in flight.
module go_to_point_proportional_steer_core import gtp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    gtp_pose_if.sink    i_pose,
    gtp_cmd_if.source   o_cmd
);
    logic signed [15:0] r_target_x, r_target_y;
    logic        [15:0] r_gain, r_max_speed, r_arrive_thr;
    logic        [10:0] r_head_thr;
    logic               adv;
    logic               v_chain [SQRT_STEPS+1];
    t_iter              d_chain [SQRT_STEPS+1];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_x   <= 16'sd256;
            r_target_y   <= 16'sd256;
            r_gain       <= 16'd256;
            r_max_speed  <= 16'd768;
            r_arrive_thr <= 16'd26;
            r_head_thr   <= 11'd51;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TARGET_X:   r_target_x   <= i_cfg_data;
                REG_TARGET_Y:   r_target_y   <= i_cfg_data;
                REG_GAIN:       r_gain       <= i_cfg_data;
                REG_MAX_SPEED:  r_max_speed  <= i_cfg_data;
                REG_ARRIVE_THR: r_arrive_thr <= i_cfg_data;
                REG_HEAD_THR:   r_head_thr   <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // pipeline advance
    assign adv          = !o_cmd.valid || o_cmd.ready;
    assign i_pose.ready = adv;

    gtp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (adv),
        .i_valid    (i_pose.valid),
        .i_pos_x    (i_pose.pos_x),
        .i_pos_y    (i_pose.pos_y),
        .i_heading  (i_pose.heading),
        .i_target_x (r_target_x),
        .i_target_y (r_target_y),
        .o_valid    (v_chain[0]),
        .o_data     (d_chain[0])
    );

    // iteration stages
    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_iter
        gtp_iter u_iter (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_step  (STEP_W'(g)),
            .i_valid (v_chain[g]),
            .i_data  (d_chain[g]),
            .o_valid (v_chain[g+1]),
            .o_data  (d_chain[g+1])
        );
    end

    gtp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (adv),
        .i_valid        (v_chain[SQRT_STEPS]),
        .i_data         (d_chain[SQRT_STEPS]),
        .i_gain         (r_gain),
        .i_max_speed    (r_max_speed),
        .i_arrive_thr   (r_arrive_thr),
        .i_head_thr     (r_head_thr),
        .o_valid        (o_cmd.valid),
        .o_linear_speed (o_cmd.linear_speed),
        .o_turn_rate    (o_cmd.turn_rate)
    );

    // a stalled command holds the whole pipeline
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.valid && !o_cmd.ready) |-> !i_pose.ready)
        else $error("pose accepted while command stalled");

    // never drive and turn at once
    a_one_branch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.valid |-> (o_cmd.linear_speed == 16'd0 || o_cmd.turn_rate == 11'd0))
        else $error("speed and turn both non-zero");

    // speed respects the clamp
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.valid |-> (o_cmd.linear_speed <= r_max_speed))
        else $error("speed above clamp");

    // turning only above the heading threshold
    a_turn_thr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.valid && o_cmd.turn_rate != 11'd0) |-> (o_cmd.turn_rate > r_head_thr))
        else $error("turn at or below threshold");
endmodule

### tb/sv/go_to_point_proportional_steer_core_tb.sv
// testbench: go-to-point steering core against a behavioural predictor of its commands
module go_to_point_proportional_steer_core_tb import gtp_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int N_POSES     = 900;
    localparam int LONG_HOLD   = 120;

    localparam logic [1:0] JOB_POSE  = 2'd0;
    localparam logic [1:0] JOB_CFG   = 2'd1;
    localparam logic [1:0] JOB_DRAIN = 2'd2;

    // indexes outside the register map, writes there are ignored
    localparam logic [2:0] REG_NONE_A = 3'd6;
    localparam logic [2:0] REG_NONE_B = 3'd7;

    typedef struct packed {
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [10:0] heading;
    } t_pose;

    typedef struct packed {
        logic [15:0] linear_speed;
        logic [10:0] turn_rate;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  cfg_idx;
        logic [15:0] cfg_data;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [10:0] heading;
    } t_job;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;

    gtp_pose_if pose_ch ();
    gtp_cmd_if  cmd_ch ();

    go_to_point_proportional_steer_core uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_pose    (pose_ch.sink),
        .o_cmd     (cmd_ch.source)
    );

    always #2 i_clk = ~i_clk;

    // shadow copy of the configuration registers
    logic signed [15:0] goal_x    = 16'sd256;
    logic signed [15:0] goal_y    = 16'sd256;
    logic        [15:0] kp_gain   = 16'd256;
    logic        [15:0] speed_cap = 16'd768;
    logic        [15:0] stop_dist = 16'd26;
    logic        [10:0] turn_thr  = 11'd51;

    t_job  job_queue[$];
    t_cmd  cmd_expected[$];
    int    n_errors = 0;
    int    n_cmds = 0;
    int    n_sent = 0;
    int    n_turns = 0;
    int    n_drives = 0;
    int    n_stops = 0;
    int    n_cfg_writes = 0;
    int    n_drains = 0;
    int    n_holds = 0;
    int    hold_left = 0;
    int    cycle_count = 0;
    logic  sink_hold = 1'b0;
    logic  pose_taken = 1'b0;
    int    send_gap = 0;
    int    recv_gap = 0;
    int    send_gap_max = 3;
    int    recv_gap_max = 3;

    // floor of arithmetic shift right
    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint n);
        longint r;
        r = 0;
        for (int b = 20; b >= 0; b--) begin
            if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= n)
                r += longint'(1) << b;
        end
        return r;
    endfunction

    // vectoring-mode bearing in Q.16 radians
    function automatic longint bearing_q16(longint ry, longint rx);
        longint x, y, z, t, xs, ys;
        longint atab[16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                             256, 128, 64, 32, 16, 8, 4, 2};
        x = rx * 4096;
        y = ry * 4096;
        z = 0;
        if (rx == 0 && ry == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = longint'(HALF_PI_Q16);
            end else begin
                t = x; x = -y; y = t; z = -longint'(HALF_PI_Q16);
            end
        end
        for (int i = 0; i < CORDIC_STEPS && i < 16; i++) begin
            xs = shr_floor(x, i);
            ys = shr_floor(y, i);
            if (y > 0) begin
                x += ys; y -= xs; z += atab[i];
            end else begin
                x -= ys; y += xs; z -= atab[i];
            end
        end
        return z;
    endfunction

    function automatic t_cmd steer_command(t_pose p);
        t_cmd   c;
        longint dx, dy, distance, brg, err, lin;
        dx = longint'(goal_x) - longint'($signed(p.pos_x));
        dy = longint'(goal_y) - longint'($signed(p.pos_y));
        distance = int_sqrt(dx * dx + dy * dy);
        c = '0;
        if (distance > longint'(stop_dist)) begin
            brg = shr_floor(bearing_q16(dy, dx) + 128, 8);
            err = brg - longint'($signed(p.heading));
            if (err < 0) err = -err;
            if (err > longint'(turn_thr)) begin
                c.turn_rate = err[10:0];
            end else begin
                lin = (longint'(kp_gain) * distance) >>> 8;
                if (lin > longint'(speed_cap)) lin = longint'(speed_cap);
                c.linear_speed = lin[15:0];
            end
        end
        return c;
    endfunction

    function automatic int pick_gap(int mx);
        if (mx == 0) return 0;
        if ($urandom_range(0, 19) == 0) return int'($urandom_range(10, 40));
        return int'($urandom_range(0, mx));
    endfunction

    function automatic int rand_int(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at command %0d: %s got %0d expected %0d", n_cmds, what, got, want);
        n_errors++;
    endtask

    task automatic push_pose(int px, int py, int hd);
        t_job j;
        j = '0;
        j.kind    = JOB_POSE;
        j.pos_x   = 16'(px);
        j.pos_y   = 16'(py);
        j.heading = 11'(hd);
        job_queue.push_back(j);
    endtask

    task automatic push_cfg(logic [2:0] idx, logic [15:0] data);
        t_job j;
        j = '0;
        j.kind     = JOB_CFG;
        j.cfg_idx  = idx;
        j.cfg_data = data;
        job_queue.push_back(j);
    endtask

    task automatic push_drain();
        t_job j;
        j = '0;
        j.kind = JOB_DRAIN;
        job_queue.push_back(j);
    endtask

    task automatic finish_run();
        $display("ran %0d poses in %0d cycles: %0d turning, %0d driving, %0d zero commands",
                 n_sent, cycle_count, n_turns, n_drives, n_stops);
        $display("with %0d register writes, %0d long sink stalls and %0d drain pauses",
                 n_cfg_writes, n_holds, n_drains);
        if (n_errors == 0 && n_cmds == N_POSES)
            $display("go_to_point_proportional_steer_core test passed");
        else
            $display("go_to_point_proportional_steer_core test failed");
        $finish;
    endtask

    // stimulus plan and reset
    initial begin
        int  tx, ty, px, py, hd, mode;
        real ang;
        tx = 256;
        ty = 256;
        for (int i = 0; i < N_POSES; i++) begin
            // register updates between groups of poses
            if (i == 150) begin
                tx = rand_int(-32768, 32767);
                ty = rand_int(-32768, 32767);
                push_cfg(REG_TARGET_X, 16'(tx));
                push_cfg(REG_TARGET_Y, 16'(ty));
            end else if (i == 300) begin
                push_cfg(REG_GAIN, 16'hFFFF);
                push_cfg(REG_MAX_SPEED, 16'hFFFF);
                push_cfg(REG_HEAD_THR, 16'd300);
            end else if (i == 450) begin
                push_drain();
                push_cfg(REG_ARRIVE_THR, 16'd0);
                push_cfg(REG_HEAD_THR, 16'd0);
                push_cfg(REG_GAIN, 16'd100);
                push_cfg(REG_MAX_SPEED, 16'd2000);
            end else if (i == 600) begin
                tx = 32767;
                ty = -32768;
                push_cfg(REG_TARGET_X, 16'(tx));
                push_cfg(REG_TARGET_Y, 16'(ty));
                push_cfg(REG_ARRIVE_THR, 16'd40000);
                push_cfg(REG_HEAD_THR, 16'd2047);
                push_cfg(REG_GAIN, 16'(rand_int(0, 65535)));
            end else if (i == 750) begin
                push_cfg(REG_NONE_A, 16'h1234);
                push_cfg(REG_NONE_B, 16'hFFFF);
                tx = 256;
                ty = 256;
                push_cfg(REG_TARGET_X, 16'(tx));
                push_cfg(REG_TARGET_Y, 16'(ty));
                push_cfg(REG_GAIN, 16'd256);
                push_cfg(REG_MAX_SPEED, 16'd768);
                push_cfg(REG_ARRIVE_THR, 16'd26);
                push_cfg(REG_HEAD_THR, 16'd51);
            end
            if (i == 250 || i == 700) push_drain();

            mode = rand_int(0, 9);
            px = rand_int(-32768, 32767);
            py = rand_int(-32768, 32767);
            hd = rand_int(-805, 805);
            case (mode)
                2: begin
                    px = tx + rand_int(-40, 40);
                    py = ty + rand_int(-40, 40);
                end
                3: begin
                    px = tx;
                    py = ty;
                end
                4, 5, 6: begin
                    px = tx + rand_int(-3000, 3000);
                    py = ty + rand_int(-3000, 3000);
                    ang = $atan2(real'(ty - py), real'(tx - px));
                    hd = $rtoi(ang * 256.0) + rand_int(-60, 60);
                end
                7: hd = rand_int(-1024, 1023);
                8: begin
                    case (rand_int(0, 3))
                        0: px = -32768;
                        1: px = 32767;
                        2: px = 0;
                        default: px = tx;
                    endcase
                    case (rand_int(0, 3))
                        0: py = -32768;
                        1: py = 32767;
                        2: py = 0;
                        default: py = ty;
                    endcase
                end
                9: begin
                    if (rand_int(0, 1) == 0) begin
                        px = tx + rand_int(-3000, 3000);
                        py = ty;
                    end else begin
                        px = tx;
                        py = ty + rand_int(-3000, 3000);
                    end
                end
                default: ;
            endcase
            push_pose(px, py, hd);
        end
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // shadow register update
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_we) begin
            case (i_cfg_idx)
                REG_TARGET_X:   goal_x    <= i_cfg_data;
                REG_TARGET_Y:   goal_y    <= i_cfg_data;
                REG_GAIN:       kp_gain   <= i_cfg_data;
                REG_MAX_SPEED:  speed_cap <= i_cfg_data;
                REG_ARRIVE_THR: stop_dist <= i_cfg_data;
                REG_HEAD_THR:   turn_thr  <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // predictor: expected command for every accepted pose transaction
    always @(posedge i_clk) begin
        t_pose p;
        if (i_rst_n && pose_ch.valid && pose_ch.ready) begin
            p.pos_x   = pose_ch.pos_x;
            p.pos_y   = pose_ch.pos_y;
            p.heading = pose_ch.heading;
            cmd_expected.push_back(steer_command(p));
            n_sent++;
        end
        pose_taken <= i_rst_n && pose_ch.valid && pose_ch.ready;
    end

    // pose and register driver: offers queued transactions with random gaps
    always @(negedge i_clk) begin
        t_job j;
        logic v_n;
        logic we_n;
        int   gap_n;
        v_n   = pose_ch.valid;
        we_n  = 1'b0;
        gap_n = send_gap;
        if (!i_rst_n) begin
            v_n   = 1'b0;
            gap_n = 0;
        end else if (pose_ch.valid && !pose_taken) begin
            v_n = 1'b1;
        end else if (gap_n > 0) begin
            v_n   = 1'b0;
            gap_n = gap_n - 1;
        end else begin
            v_n = 1'b0;
            if (job_queue.size() != 0) begin
                j = job_queue[0];
                case (j.kind)
                    JOB_POSE: begin
                        pose_ch.pos_x   <= j.pos_x;
                        pose_ch.pos_y   <= j.pos_y;
                        pose_ch.heading <= j.heading;
                        v_n   = 1'b1;
                        gap_n = pick_gap(send_gap_max);
                        void'(job_queue.pop_front());
                    end
                    JOB_CFG: begin
                        // registers change only with nothing in flight
                        if (cmd_expected.size() == 0) begin
                            i_cfg_idx  <= j.cfg_idx;
                            i_cfg_data <= j.cfg_data;
                            we_n = 1'b1;
                            n_cfg_writes++;
                            void'(job_queue.pop_front());
                        end
                    end
                    JOB_DRAIN: begin
                        if (cmd_expected.size() == 0) begin
                            n_drains++;
                            void'(job_queue.pop_front());
                        end
                    end
                    default: void'(job_queue.pop_front());
                endcase
            end
        end
        pose_ch.valid <= v_n;
        i_cfg_we      <= we_n;
        send_gap      <= gap_n;
    end

    // long sink stalls, counted in cycles
    always @(negedge i_clk) begin
        int left;
        left = hold_left;
        if (left > 0) begin
            left = left - 1;
        end else if (i_rst_n && n_holds < 2 && n_sent >= (n_holds + 1) * 300) begin
            left = LONG_HOLD;
            n_holds <= n_holds + 1;
        end
        hold_left <= left;
        sink_hold <= (left > 0);
    end

    // command sink readiness with random gaps
    always @(negedge i_clk) begin
        logic rdy;
        int   gap_n;
        gap_n = recv_gap;
        if (!i_rst_n) begin
            rdy   = 1'b0;
            gap_n = 0;
        end else if (sink_hold) begin
            rdy = 1'b0;
        end else if (gap_n > 0) begin
            rdy   = 1'b0;
            gap_n = gap_n - 1;
        end else begin
            rdy = 1'b1;
            if ($urandom_range(0, 3) == 0) gap_n = pick_gap(recv_gap_max);
        end
        cmd_ch.ready <= rdy;
        recv_gap     <= gap_n;
    end

    // monitor: checks each command transaction and ends the run
    always @(posedge i_clk) begin
        t_cmd want;
        cycle_count++;
        if (i_rst_n && cmd_ch.valid && cmd_ch.ready) begin
            if (cmd_expected.size() == 0) begin
                report_mismatch("unexpected command, speed", int'(cmd_ch.linear_speed), 0);
            end else begin
                want = cmd_expected.pop_front();
                if (cmd_ch.linear_speed !== want.linear_speed)
                    report_mismatch("linear_speed", int'(cmd_ch.linear_speed),
                                    int'(want.linear_speed));
                if (cmd_ch.turn_rate !== want.turn_rate)
                    report_mismatch("turn_rate", int'(cmd_ch.turn_rate),
                                    int'(want.turn_rate));
                if (want.turn_rate != 11'd0) n_turns++;
                else if (want.linear_speed != 16'd0) n_drives++;
                else n_stops++;
            end
            n_cmds++;
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            report_mismatch("cycle limit, outstanding", cmd_expected.size(), 0);
            finish_run();
        end else if (i_rst_n && job_queue.size() == 0 && pose_ch.valid === 1'b0
                     && cmd_expected.size() == 0) begin
            if (n_cmds != N_POSES) report_mismatch("command count", n_cmds, N_POSES);
            finish_run();
        end
    end

endmodule

### go_to_point_proportional_steer_core.f
sv/gtp_pkg.sv
sv/gtp_pose_if.sv
sv/gtp_cmd_if.sv
sv/gtp_front.sv
sv/gtp_iter.sv
sv/gtp_back.sv
sv/go_to_point_proportional_steer_core.sv
tb/sv/go_to_point_proportional_steer_core_tb.sv
